// ----- design/hsv2rgb_pkg.sv -----
// Package: pixel field types, fixed-point constants and hue sector codes.
`timescale 1ns / 1ps
package hsv2rgb_pkg;

  typedef logic [14:0] hue_t;
  typedef logic [7:0]  chan_t;

  // One degree is 64 hue units.
  localparam int unsigned HueSector = 3840;
  localparam int unsigned HuePair   = 2 * HueSector;

  // floor(p / 255) == (p * RecipFull) >> RecipFullShift for any 16-bit p
  localparam int unsigned RecipFull      = 32897;
  localparam int unsigned RecipFullShift = 23;

  // floor(y / 15) == (y * RecipFifteen) >> RecipFifteenShift for y < 3840
  localparam int unsigned RecipFifteen      = 2185;
  localparam int unsigned RecipFifteenShift = 15;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

endpackage

// ----- design/hsv2rgb_if.sv -----
// Interfaces: HSV pixel request channel and RGB pixel result channel.
`timescale 1ns / 1ps
interface hsv2rgb_in_if;
  logic                valid;
  logic                ready;
  hsv2rgb_pkg::hue_t   hue;
  hsv2rgb_pkg::chan_t  saturation;
  hsv2rgb_pkg::chan_t  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
  logic                valid;
  logic                ready;
  hsv2rgb_pkg::chan_t  red;
  hsv2rgb_pkg::chan_t  green;
  hsv2rgb_pkg::chan_t  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- design/hsv_to_rgb_converter.sv -----
// HSV to RGB pixel converter, one pixel per clock through a five-stage pipeline.
// Takes one HSV request per cycle while the pipe is not stalled and returns its
// RGB result from the stage 5 output register. The four fixed-point multiplies
// (value times saturation, chroma times hue weight, and the reciprocal
// multiplies for /255 and /15) each sit in their own stage. The whole pipe
// advances together and holds while a result waits in the output register
// with out ready low; nothing is dropped or repeated under stalls.
`timescale 1ns / 1ps
module hsv_to_rgb_converter (
  input logic          clk,
  input logic          rst_n,
  hsv2rgb_in_if.sink   in_pix,
  hsv2rgb_out_if.source out_pix
);
  import hsv2rgb_pkg::*;

  localparam logic [14:0] Sec1 = 15'(HueSector);
  localparam logic [14:0] Sec2 = 15'(2 * HueSector);
  localparam logic [14:0] Sec3 = 15'(3 * HueSector);
  localparam logic [14:0] Sec4 = 15'(4 * HueSector);
  localparam logic [14:0] Sec5 = 15'(5 * HueSector);
  localparam logic [14:0] Pair1 = 15'(HuePair);
  localparam logic [14:0] Pair2 = 15'(2 * HuePair);
  localparam logic [14:0] Pair3 = 15'(3 * HuePair);
  localparam logic [14:0] Pair4 = 15'(4 * HuePair);
  localparam logic [12:0] SecT  = 13'(HueSector);

  logic advance;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1
  logic [15:0] p1_r, p1_nxt;
  logic [12:0] t1_r, t1_nxt;
  sector_t     sec1_r, sec1_nxt;
  chan_t       val1_r;

  // stage 2
  logic [31:0] q2_r;
  logic [11:0] w2_r, w2_nxt;
  logic [12:0] hue_dist;
  sector_t     sec2_r;
  chan_t       val2_r;

  // stage 3
  chan_t       c3_r, c3_nxt, m3_r;
  logic [19:0] xp3_r;
  sector_t     sec3_r;

  // stage 4
  logic [23:0] xq4_r;
  chan_t       c4_r, m4_r;
  sector_t     sec4_r;

  // stage 5 (output)
  chan_t       x5;
  chan_t       r5_r, g5_r, b5_r, r5_nxt, g5_nxt, b5_nxt;

  assign advance       = !v5_r || out_pix.ready;
  assign in_pix.ready  = advance;
  assign out_pix.valid = v5_r;
  assign out_pix.red   = r5_r;
  assign out_pix.green = g5_r;
  assign out_pix.blue  = b5_r;

  always_comb begin
    if (in_pix.hue >= Sec5) begin
      sec1_nxt = SEC_MAG_RED;
    end else if (in_pix.hue >= Sec4) begin
      sec1_nxt = SEC_BLU_MAG;
    end else if (in_pix.hue >= Sec3) begin
      sec1_nxt = SEC_CYN_BLU;
    end else if (in_pix.hue >= Sec2) begin
      sec1_nxt = SEC_GRN_CYN;
    end else if (in_pix.hue >= Sec1) begin
      sec1_nxt = SEC_YEL_GRN;
    end else begin
      sec1_nxt = SEC_RED_YEL;
    end

    if (in_pix.hue >= Pair4) begin
      t1_nxt = 13'(in_pix.hue - Pair4);
    end else if (in_pix.hue >= Pair3) begin
      t1_nxt = 13'(in_pix.hue - Pair3);
    end else if (in_pix.hue >= Pair2) begin
      t1_nxt = 13'(in_pix.hue - Pair2);
    end else if (in_pix.hue >= Pair1) begin
      t1_nxt = 13'(in_pix.hue - Pair1);
    end else begin
      t1_nxt = in_pix.hue[12:0];
    end

    p1_nxt = 16'(in_pix.brightness) * 16'(in_pix.saturation);
  end

  always_comb begin
    hue_dist = (t1_r >= SecT) ? (t1_r - SecT) : (SecT - t1_r);
    w2_nxt   = 12'(SecT - hue_dist);
    c3_nxt   = q2_r[RecipFullShift +: 8];
    x5       = xq4_r[RecipFifteenShift +: 8];
  end

  // place chroma and secondary by sector, then add the offset
  always_comb begin
    unique case (sec4_r)
      SEC_RED_YEL: begin
        r5_nxt = c4_r; g5_nxt = x5;   b5_nxt = '0;
      end
      SEC_YEL_GRN: begin
        r5_nxt = x5;   g5_nxt = c4_r; b5_nxt = '0;
      end
      SEC_GRN_CYN: begin
        r5_nxt = '0;   g5_nxt = c4_r; b5_nxt = x5;
      end
      SEC_CYN_BLU: begin
        r5_nxt = '0;   g5_nxt = x5;   b5_nxt = c4_r;
      end
      SEC_BLU_MAG: begin
        r5_nxt = x5;   g5_nxt = '0;   b5_nxt = c4_r;
      end
      default: begin
        r5_nxt = c4_r; g5_nxt = '0;   b5_nxt = x5;
      end
    endcase
    r5_nxt = r5_nxt + m4_r;
    g5_nxt = g5_nxt + m4_r;
    b5_nxt = b5_nxt + m4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_pix.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_r   <= p1_nxt;
      t1_r   <= t1_nxt;
      sec1_r <= sec1_nxt;
      val1_r <= in_pix.brightness;

      q2_r   <= 32'(p1_r) * 32'(RecipFull);
      w2_r   <= w2_nxt;
      sec2_r <= sec1_r;
      val2_r <= val1_r;

      c3_r   <= c3_nxt;
      m3_r   <= val2_r - c3_nxt;
      xp3_r  <= 20'(c3_nxt) * 20'(w2_r);
      sec3_r <= sec2_r;

      // chroma * weight / 3840 = ((chroma * weight) >> 8) / 15
      xq4_r  <= 24'(xp3_r[19:8]) * 24'(RecipFifteen);
      c4_r   <= c3_r;
      m4_r   <= m3_r;
      sec4_r <= sec3_r;

      r5_r   <= r5_nxt;
      g5_r   <= g5_nxt;
      b5_r   <= b5_nxt;
    end
  end

endmodule
